[hw/rtl/prq_pkg.sv]
`default_nettype none

package prq_pkg;

	// Sizes of the task table and of the priority range
	localparam int TASK_SLOTS = 64;
	localparam int LEVELS     = 32;
	localparam int TASK_W     = 6;
	localparam int LVL_W      = 5;
	localparam int OP_W       = 2;

	typedef logic [TASK_W-1:0] task_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	typedef enum logic [OP_W-1:0] {
		OP_MAKE  = 2'd0,
		OP_SCHED = 2'd1,
		OP_EXIT  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_RD,
		ST_POP_WR,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic pop_rd;
		logic pop_wr;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_sched;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/prq_ctrl.sv]
`default_nettype none

module prq_ctrl import prq_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register and output register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
			ST_EXEC:   state_nxt = sts.is_sched ? ST_POP_RD : ST_DONE;
			ST_POP_RD: state_nxt = ST_POP_WR;
			ST_POP_WR: state_nxt = ST_DONE;
			ST_DONE:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_EXEC:   cmd.exec = 1'b1;
			ST_POP_RD: cmd.pop_rd = 1'b1;
			ST_POP_WR: cmd.pop_wr = 1'b1;
			ST_DONE:   cmd.load_out = out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/prq_dpath.sv]
`default_nettype none

module prq_dpath import prq_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  wire  [OP_W-1:0]   opcode,
	input  wire  [TASK_W-1:0] task_index,
	input  wire  [LVL_W-1:0]  priority_req,
	output logic              active_valid,
	output logic [TASK_W-1:0] active_index,
	output logic [LVL_W-1:0]  active_priority
);

	// Latched request
	op_t   op_q;
	task_t tix_q;
	lvl_t  pri_q;

	// Level FIFO pointers and non-empty mask
	task_t             head_q [LEVELS];
	task_t             tail_q [LEVELS];
	logic [LEVELS-1:0] mask_q;

	// Next-link memory with per-entry valid bits, task level memory
	task_t             nl_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] nl_vld_q;
	lvl_t              tl_mem [TASK_SLOTS];

	task_t act_q;
	lvl_t  act_lvl_q;

	// Pop stage registers
	logic  pop_en_s1;
	lvl_t  pop_lvl_s1;
	task_t pop_t_s1;
	task_t nl_rd_s1;
	logic  nl_rv_s1;
	lvl_t  tl_rd_s1;

	logic  make_ok;
	logic  push_en;
	lvl_t  push_lvl;
	task_t push_task;
	task_t push_tl;
	lvl_t  ffs_lvl;
	task_t pop_head;
	task_t pop_nx;

	assign sts.is_sched = (op_q == OP_SCHED);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op_t'(opcode);
			tix_q <= task_index;
			pri_q <= priority_req;
		end
	end

	// Push decode: make-ready appends the request, schedule re-queues the active task
	assign make_ok = (op_q == OP_MAKE) && (tix_q != '0)
		&& (int'(tix_q) < TASK_SLOTS) && (int'(pri_q) < LEVELS);

	always_comb begin
		push_en   = 1'b0;
		push_lvl  = pri_q;
		push_task = tix_q;
		if (cmd.exec) begin
			if (make_ok) begin
				push_en = 1'b1;
			end else if (op_q == OP_SCHED && act_q != '0) begin
				push_en   = 1'b1;
				push_lvl  = act_lvl_q;
				push_task = act_q;
			end
		end
	end

	assign push_tl = tail_q[push_lvl];

	// Lowest-numbered non-empty level
	always_comb begin
		ffs_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (mask_q[i])
				ffs_lvl = LVL_W'(i);
		end
	end

	assign pop_head = head_q[ffs_lvl];
	assign pop_nx   = (pop_t_s1 != '0 && nl_rv_s1) ? nl_rd_s1 : '0;

	// Pointer tables, mask, link valid bits and active task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			mask_q    <= '0;
			nl_vld_q  <= '0;
			act_q     <= '0;
			act_lvl_q <= '0;
		end else begin
			if (push_en) begin
				if (push_tl != '0)
					nl_vld_q[push_tl] <= 1'b1;
				else
					head_q[push_lvl] <= push_task;
				tail_q[push_lvl] <= push_task;
				mask_q[push_lvl] <= 1'b1;
			end
			if (cmd.exec && make_ok && tix_q == act_q)
				act_lvl_q <= pri_q;
			if (cmd.exec && op_q == OP_EXIT)
				act_q <= '0;
			if (cmd.pop_wr && pop_en_s1) begin
				head_q[pop_lvl_s1] <= pop_nx;
				if (pop_nx == '0) begin
					tail_q[pop_lvl_s1] <= '0;
					mask_q[pop_lvl_s1] <= 1'b0;
				end
				if (pop_t_s1 != '0)
					nl_vld_q[pop_t_s1] <= 1'b0;
				act_q     <= pop_t_s1;
				act_lvl_q <= tl_rd_s1;
			end
		end
	end

	// Memory writes
	always_ff @(posedge clk) begin
		if (push_en && push_tl != '0)
			nl_mem[push_tl] <= push_task;
		if (cmd.exec && make_ok)
			tl_mem[tix_q] <= pri_q;
	end

	// Pop read stage, registered memory reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pop_en_s1 <= 1'b0;
		else if (cmd.pop_rd)
			pop_en_s1 <= (mask_q != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_rd) begin
			pop_lvl_s1 <= ffs_lvl;
			pop_t_s1   <= pop_head;
			nl_rd_s1   <= nl_mem[pop_head];
			nl_rv_s1   <= nl_vld_q[pop_head];
			tl_rd_s1   <= tl_mem[pop_head];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			active_valid    <= (act_q != '0);
			active_index    <= act_q;
			active_priority <= (act_q != '0) ? act_lvl_q : '0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/priority_ready_queue_scheduler.sv]
// Priority ready-queue scheduler: per-level linked FIFOs of task indices.
// Input channel (in_valid/in_ready) carries opcode, task_index, priority_req:
// make ready (append a task at a level), schedule (re-queue the active task,
// pop the head of the lowest-numbered non-empty level) or exit (drop the active task).
// Output channel (out_valid/out_ready) returns one transfer per operation:
// active_valid, active_index and active_priority as they stand afterwards.
// One operation is in flight at a time. Make-ready, exit and no-op only pass
// through execute; for schedule the controller steps through execute,
// a registered read of the link and level memories, and the pop write-back.
// A result held in the output register does not stop the next input transfer;
// the block only waits at completion if the previous result is still unread.
// Reset empties every level, clears the link table valid bits and the active
// task; the task level table is not cleared and needs no clearing pass.
`default_nettype none

module priority_ready_queue_scheduler import prq_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [OP_W-1:0]   opcode,
	input  wire  [TASK_W-1:0] task_index,
	input  wire  [LVL_W-1:0]  priority_req,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              active_valid,
	output logic [TASK_W-1:0] active_index,
	output logic [LVL_W-1:0]  active_priority
);

	cmd_t cmd;
	sts_t sts;

	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prq_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (opcode),
		.task_index      (task_index),
		.priority_req    (priority_req),
		.active_valid    (active_valid),
		.active_index    (active_index),
		.active_priority (active_priority)
	);

endmodule

`default_nettype wire

[hw/rtl/prq_chk.sv]
`default_nettype none

module prq_chk import prq_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire              active_valid,
	input wire [TASK_W-1:0] active_index,
	input wire [LVL_W-1:0]  active_priority
);

	// One operation at a time: no input transfer in the cycle after one
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an operation is in flight");

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(active_index) && $stable(active_priority))
		else $error("stalled result changed");

	// No active task reports all zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active_valid |-> active_index == '0 && active_priority == '0)
		else $error("idle result carries non-zero fields");

	// An active task is never index zero
	a_active_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active_valid |-> active_index != '0)
		else $error("active task reported as index zero");

endmodule

bind priority_ready_queue_scheduler prq_chk u_prq_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.active_valid    (active_valid),
	.active_index    (active_index),
	.active_priority (active_priority)
);

`default_nettype wire

[bench/priority_ready_queue_scheduler_tb.sv]
`timescale 1ns / 100ps

module priority_ready_queue_scheduler_tb;
	import prq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	// One reported state of the active task
	typedef struct packed {
		logic  vld;
		task_t idx;
		lvl_t  pri;
	} active_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	op_t   opcode;
	task_t task_index;
	lvl_t  priority_req;
	logic  out_valid;
	logic  out_ready;
	logic  active_valid;
	task_t active_index;
	lvl_t  active_priority;

	// Mirror of the scheduler tables
	task_t             q_head [LEVELS];
	task_t             q_tail [LEVELS];
	logic [LEVELS-1:0] ready_lvls;
	task_t             link [TASK_SLOTS];
	lvl_t              lvl_of [TASK_SLOTS];
	task_t             running;
	int                queued_cnt [TASK_SLOTS];

	active_t pending_active [$];

	bit          idle_on;
	int unsigned sink_hold;
	int unsigned cycle_cnt   = 0;
	int unsigned err_cnt     = 0;
	int unsigned sent_cnt    = 0;
	int unsigned sched_cnt   = 0;
	int unsigned checked_cnt = 0;
	int unsigned held_cnt    = 0;

	priority_ready_queue_scheduler u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.task_index      (task_index),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.active_valid    (active_valid),
		.active_index    (active_index),
		.active_priority (active_priority)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("priority_ready_queue_scheduler_tb: FAIL");
		$finish;
	end

	// Append a task at the tail of a level
	function automatic void enqueue_task(lvl_t lvl, task_t t);
		if (q_tail[lvl] != '0)
			link[q_tail[lvl]] = t;
		else
			q_head[lvl] = t;
		q_tail[lvl]     = t;
		ready_lvls[lvl] = 1'b1;
		queued_cnt[t]++;
	endfunction

	// Take the head of a level; a level left without a successor is cleared
	function automatic task_t dequeue_level(lvl_t lvl);
		task_t t;
		task_t nx;
		t  = q_head[lvl];
		nx = '0;
		if (t != '0) begin
			nx      = link[t];
			link[t] = '0;
			if (queued_cnt[t] > 0)
				queued_cnt[t]--;
		end
		q_head[lvl] = nx;
		if (nx == '0) begin
			q_tail[lvl]     = '0;
			ready_lvls[lvl] = 1'b0;
		end
		return t;
	endfunction

	// Update the mirror with one operation and give the active task after it
	function automatic active_t apply_op(op_t op, task_t tix, lvl_t pri);
		active_t r;
		int      top_lvl;
		top_lvl = 0;
		case (op)
			OP_MAKE: begin
				// task index zero is not a task
				if (tix != '0) begin
					lvl_of[tix] = pri;
					enqueue_task(pri, tix);
				end
			end
			OP_SCHED: begin
				if (running != '0)
					enqueue_task(lvl_of[running], running);
				if (ready_lvls != '0) begin
					for (int l = LEVELS - 1; l >= 0; l--)
						if (ready_lvls[l])
							top_lvl = l;
					running = dequeue_level(lvl_t'(top_lvl));
				end
			end
			OP_EXIT: running = '0;
			default: ;
		endcase
		r.vld = (running != '0);
		r.idx = running;
		r.pri = r.vld ? lvl_of[running] : '0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	// Offer one operation and wait for its transfer
	task automatic send_op(op_t op, task_t tix, lvl_t pri);
		int gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		task_index   <= tix;
		priority_req <= pri;
		@(posedge clk);
		while (!in_ready) begin
			held_cnt++;
			@(posedge clk);
		end
		pending_active.push_back(apply_op(op, tix, pri));
		sent_cnt++;
		if (op == OP_SCHED)
			sched_cnt++;
	endtask

	// Stop offering until every outstanding result has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_active.size() != 0) @(posedge clk);
	endtask

	// Random operation; clean traffic never pushes a task that is queued or active
	task automatic send_random(bit clean);
		int    r;
		int    tries;
		task_t t;
		lvl_t  p;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, 1) ? lvl_t'($urandom_range(0, 31)) : lvl_t'($urandom_range(0, 3));
		t = task_t'($urandom_range(0, 63));
		if (!clean) begin
			send_op(op_t'($urandom_range(0, 3)), t, p);
		end else if (r < 47) begin
			tries = 0;
			t     = task_t'($urandom_range(1, 63));
			while ((queued_cnt[t] != 0 || t == running) && tries < 16) begin
				t = task_t'($urandom_range(1, 63));
				tries++;
			end
			if (tries < 16)
				send_op(OP_MAKE, t, p);
			else
				send_op(OP_SCHED, t, p);
		end else if (r < 90) begin
			send_op(OP_SCHED, t, p);
		end else if (r < 97) begin
			send_op(OP_EXIT, t, p);
		end else begin
			send_op(OP_NOP, t, p);
		end
	endtask

	// Empty scheduler: schedule, exit and no-op report no task; task zero ignored
	task automatic test_idle_ops();
		send_op(OP_SCHED, '0, '0);
		send_op(OP_EXIT, '0, '0);
		send_op(OP_NOP, 6'h3f, 5'h1f);
		send_op(OP_MAKE, '0, 5'd31);
		send_op(OP_SCHED, 6'h3f, '0);
		wait_drained();
	endtask

	// Lowest-numbered level first, FIFO within a level, active task re-queued on schedule
	task automatic test_priority_order();
		send_op(OP_MAKE, 6'd63, 5'd31);
		send_op(OP_MAKE, 6'd1, 5'd0);
		send_op(OP_MAKE, 6'd5, 5'd0);
		send_op(OP_MAKE, 6'd7, 5'd16);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_NOP, '0, '0);
		send_op(OP_EXIT, '0, '0);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_SCHED, '0, '0);
		wait_drained();
	endtask

	// Already-queued task pushed again, in the same level and in another
	task automatic test_requeue_corruption();
		send_op(OP_MAKE, 6'd10, 5'd3);
		send_op(OP_MAKE, 6'd11, 5'd3);
		send_op(OP_MAKE, 6'd10, 5'd3);
		send_op(OP_MAKE, 6'd11, 5'd4);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_SCHED, '0, '0);
		send_op(OP_EXIT, '0, '0);
		wait_drained();
	endtask

	// Long receiver hold-off while operations keep coming, so the input stalls
	task automatic test_backpressure();
		sink_hold = 200;
		for (int i = 0; i < 12; i++)
			send_random(1'b1);
		wait_drained();
	endtask

	task automatic test_random_wellformed(int n);
		for (int i = 0; i < n; i++) begin
			send_random(1'b1);
			if (i % 150 == 149)
				wait_drained();
		end
	endtask

	task automatic test_random_noise(int n);
		for (int i = 0; i < n; i++)
			send_random($urandom_range(0, 1));
	endtask

	// Receiver: random stall bursts, plus a long hold when one is requested
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				sink_hold--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 6);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : chk
		active_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_active.size() == 0) begin
				report_mismatch("result with nothing outstanding, index", active_index, 0);
			end else begin
				exp_r = pending_active.pop_front();
				checked_cnt++;
				if (active_valid !== exp_r.vld)
					report_mismatch("active_valid", active_valid, exp_r.vld);
				if (active_index !== exp_r.idx)
					report_mismatch("active_index", active_index, exp_r.idx);
				if (active_priority !== exp_r.pri)
					report_mismatch("active_priority", active_priority, exp_r.pri);
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_NOP;
		task_index   = '0;
		priority_req = '0;
		out_ready    = 1'b0;
		idle_on      = 1'b1;
		sink_hold    = 0;
		ready_lvls   = '0;
		running      = '0;
		for (int i = 0; i < LEVELS; i++) begin
			q_head[i] = '0;
			q_tail[i] = '0;
		end
		for (int i = 0; i < TASK_SLOTS; i++) begin
			link[i]       = '0;
			lvl_of[i]     = '0;
			queued_cnt[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ops();
		test_priority_order();
		test_requeue_corruption();
		test_backpressure();
		test_random_wellformed(900);
		test_random_noise(250);
		// closing stretch at full rate on both sides
		idle_on = 1'b0;
		test_random_wellformed(150);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Ran %0d operations (%0d schedules), checked %0d results;", sent_cnt,
			sched_cnt, checked_cnt);
		$display("ordering, re-queue, duplicate pushes, stalls (%0d input cycles held).",
			held_cnt);
		if (err_cnt == 0)
			$display("priority_ready_queue_scheduler_tb: PASS");
		else
			$display("priority_ready_queue_scheduler_tb: FAIL");
		$finish;
	end

endmodule
